// ----- sv/gpoc_pkg.sv -----
// Shared constants, register codes and sequencer types for the grid path occupancy check.
package gpoc_pkg;

    // Map geometry
    localparam int MAX_SIDE  = 256;
    localparam int MAP_CELLS = 65536;
    localparam int SIDE_BITS = $clog2(MAX_SIDE);
    localparam int LIM_W     = SIDE_BITS + 1;
    localparam int Q_BITS    = SIDE_BITS + 2;
    localparam int STEP_W    = $clog2(Q_BITS);
    localparam int CELL_AW   = $clog2(MAP_CELLS);
    localparam int IDX_W     = SIDE_BITS + LIM_W;

    // Field widths
    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int DIV_W      = 31;
    localparam int VAL_W      = 8;
    localparam int INDEX_W    = 16;
    localparam int SIZE_W     = 9;
    localparam int S_TDATA_W  = 88;
    localparam int M_TDATA_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_W     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_H     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 3'd5;

    // Reset values of the registers
    localparam logic [DIV_W-1:0]  CELL_SIZE_RST = 31'd65536;
    localparam logic [SIZE_W-1:0] MAP_SIDE_RST  = 9'd256;
    localparam logic [VAL_W-1:0]  LIMIT_RST     = 8'd50;

    // Item kinds carried in tuser
    localparam logic KIND_MAP   = 1'b0;
    localparam logic KIND_POINT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_ABS,
        ST_DIV,
        ST_COORD,
        ST_INDEX,
        ST_READ,
        ST_CHECK,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        logic point_go;
        logic last;
        logic div_done;
        logic coord_y;
        logic out_free;
    } seq_status_t;

    typedef struct packed {
        logic ready;
        logic do_diff;
        logic do_abs;
        logic do_step;
        logic do_coord;
        logic do_index;
        logic do_read;
        logic do_check;
        logic do_emit;
    } seq_ctrl_t;

endpackage

// ----- sv/grid_path_occupancy_check.sv -----
// Checks path points against a 2D occupancy map; emits an occupied flag per path.
//
// Input words arrive on the s_ channel. tuser says what the word is: a map cell
// write (cell_index, cell_value) or a path point (point_x, point_y). tlast marks
// the final map cell, which arms the block, or the final point of a path.
// A map write is taken and the block is ready again on the next cycle.
// A path point accepted on an armed map keeps the block busy through these steps:
// each axis goes through a difference, a magnitude step, ten restoring division
// steps of the shared divider and a bounds check, then the cell index is formed,
// the map RAM is read and the value is compared. A final point then goes to an
// emit step, and its result word appears on the m_ channel on the cycle after it.
// The result word sits in an output register; the block goes on taking words
// while it waits, and only stalls in the emit step of the next final point
// until the receiver has taken the previous word.
// Configuration is written through cfg_we, cfg_index and cfg_wdata while idle.
// Reset restores the default registers, drops the loaded flag, the sticky hit
// and any pending result. The map contents are not cleared.
module grid_path_occupancy_check (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // cell_index[15:0], cell_value[23:16], point_x[55:24], point_y[87:56]
    input  logic [gpoc_pkg::S_TDATA_W-1:0]    s_tdata,
    // kind[0]
    input  logic [0:0]                        s_tuser,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // path_occupied[0], zero padding above
    output logic [gpoc_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_we,
    input  logic [gpoc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gpoc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import gpoc_pkg::*;

    // Configuration registers
    logic signed [COORD_W-1:0] origin_x_reg;
    logic signed [COORD_W-1:0] origin_y_reg;
    logic [DIV_W-1:0]          cell_size_reg;
    logic [SIZE_W-1:0]         map_w_reg;
    logic [SIZE_W-1:0]         map_h_reg;
    logic signed [VAL_W-1:0]   limit_reg;

    // Control state
    logic loaded_reg;
    logic hit_reg;
    logic m_valid_reg;
    logic coord_y_reg;
    logic [STEP_W-1:0] step_reg;

    // Datapath registers
    logic signed [COORD_W-1:0] px_reg;
    logic signed [COORD_W-1:0] py_reg;
    logic                      last_reg;
    logic [DIFF_W-1:0]         diff_reg;
    logic                      neg_reg;
    logic [COORD_W-1:0]        rem_reg;
    logic [Q_BITS-1:0]         num_reg;
    logic [Q_BITS-1:0]         quot_reg;
    logic [SIDE_BITS-1:0]      cx_reg;
    logic [SIDE_BITS-1:0]      cy_reg;
    logic                      x_ok_reg;
    logic                      y_ok_reg;
    logic [CELL_AW-1:0]        addr_reg;
    logic                      in_map_reg;
    logic [M_TDATA_W-1:0]      m_data_reg;

    // Unpacked input fields
    logic                      in_kind;
    logic [INDEX_W-1:0]        in_cell_index;
    logic [VAL_W-1:0]          in_cell_value;
    logic signed [COORD_W-1:0] in_point_x;
    logic signed [COORD_W-1:0] in_point_y;

    logic s_fire;
    logic map_we;
    logic [CELL_AW-1:0] ram_addr;
    logic [VAL_W-1:0]   ram_rdata;

    logic [DIV_W-1:0]   divisor;
    logic [LIM_W-1:0]   w_eff;
    logic [LIM_W-1:0]   h_eff;
    logic [LIM_W-1:0]   lim;
    logic [DIFF_W-1:0]  abs_full;
    logic [COORD_W-1:0] unit_rem;
    logic               unit_q;
    logic               coord_ok;
    logic [IDX_W-1:0]   cell_idx;
    logic               cell_hit;

    seq_status_t status;
    seq_ctrl_t   ctrl;

    assign in_kind       = s_tuser[0];
    assign in_cell_index = s_tdata[15:0];
    assign in_cell_value = s_tdata[23:16];
    assign in_point_x    = s_tdata[55:24];
    assign in_point_y    = s_tdata[87:56];

    assign s_tready = ctrl.ready;
    assign s_fire   = s_tvalid && ctrl.ready;
    assign map_we   = s_fire && (in_kind == KIND_MAP)
                      && (32'(in_cell_index) < 32'(MAP_CELLS));

    // A zero cell size divides as one; sides above the maximum are clamped.
    assign divisor = (cell_size_reg == '0) ? DIV_W'(1) : cell_size_reg;
    assign w_eff   = (32'(map_w_reg) > 32'(MAX_SIDE)) ? LIM_W'(MAX_SIDE) : LIM_W'(map_w_reg);
    assign h_eff   = (32'(map_h_reg) > 32'(MAX_SIDE)) ? LIM_W'(MAX_SIDE) : LIM_W'(map_h_reg);
    assign lim     = coord_y_reg ? h_eff : w_eff;

    assign abs_full = diff_reg[DIFF_W-1] ? (~diff_reg + DIFF_W'(1)) : diff_reg;

    // A negative difference is only in the map when it truncates to cell zero.
    assign coord_ok = (!neg_reg || (quot_reg == '0)) && (quot_reg < Q_BITS'(lim));
    assign cell_idx = IDX_W'(cy_reg) * IDX_W'(w_eff) + IDX_W'(cx_reg);
    assign cell_hit = in_map_reg && ($signed(ram_rdata) > limit_reg);

    assign ram_addr = ctrl.ready ? in_cell_index[CELL_AW-1:0] : addr_reg;

    assign status.point_go = s_fire && (in_kind == KIND_POINT) && loaded_reg;
    assign status.last     = last_reg;
    assign status.div_done = (step_reg == STEP_W'(Q_BITS - 1));
    assign status.coord_y  = coord_y_reg;
    assign status.out_free = !m_valid_reg || m_tready;

    gpoc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    gpoc_divstep u_divstep (
        .rem      (rem_reg),
        .bit_in   (num_reg[Q_BITS-1]),
        .divisor  (divisor),
        .rem_next (unit_rem),
        .q_bit    (unit_q)
    );

    gpoc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAP_CELLS)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (map_we),
        .re    (ctrl.do_read),
        .addr  (ram_addr),
        .wdata (in_cell_value),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            cell_size_reg <= CELL_SIZE_RST;
            map_w_reg     <= MAP_SIDE_RST;
            map_h_reg     <= MAP_SIDE_RST;
            limit_reg     <= LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ORIGIN_X:  origin_x_reg  <= cfg_wdata;
                REG_ORIGIN_Y:  origin_y_reg  <= cfg_wdata;
                REG_CELL_SIZE: cell_size_reg <= cfg_wdata[DIV_W-1:0];
                REG_MAP_W:     map_w_reg     <= cfg_wdata[SIZE_W-1:0];
                REG_MAP_H:     map_h_reg     <= cfg_wdata[SIZE_W-1:0];
                REG_LIMIT:     limit_reg     <= cfg_wdata[VAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg  <= 1'b0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            coord_y_reg <= 1'b0;
            step_reg    <= '0;
        end else begin
            if (s_fire && (in_kind == KIND_MAP) && s_tlast) begin
                loaded_reg <= 1'b1;
            end
            // A final point before the map is armed just drops the path.
            if (s_fire && (in_kind == KIND_POINT) && !loaded_reg && s_tlast) begin
                hit_reg <= 1'b0;
            end
            if (status.point_go) begin
                coord_y_reg <= 1'b0;
            end
            if (ctrl.do_coord) begin
                coord_y_reg <= 1'b1;
            end
            if (ctrl.do_abs) begin
                step_reg <= '0;
            end else if (ctrl.do_step) begin
                step_reg <= step_reg + STEP_W'(1);
            end
            if (ctrl.do_check && cell_hit) begin
                hit_reg <= 1'b1;
            end
            if (ctrl.do_emit) begin
                hit_reg     <= 1'b0;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (status.point_go) begin
            px_reg   <= in_point_x;
            py_reg   <= in_point_y;
            last_reg <= s_tlast;
        end
        if (ctrl.do_diff) begin
            diff_reg <= coord_y_reg ? (DIFF_W'(py_reg) - DIFF_W'(origin_y_reg))
                                    : (DIFF_W'(px_reg) - DIFF_W'(origin_x_reg));
        end
        // The top bits of the magnitude start the remainder, so that the first
        // step flags any quotient too large for the map in the quotient's MSB.
        if (ctrl.do_abs) begin
            neg_reg  <= diff_reg[DIFF_W-1];
            rem_reg  <= COORD_W'(abs_full[COORD_W-1:Q_BITS]);
            num_reg  <= abs_full[Q_BITS-1:0];
            quot_reg <= '0;
        end
        if (ctrl.do_step) begin
            rem_reg  <= unit_rem;
            num_reg  <= {num_reg[Q_BITS-2:0], 1'b0};
            quot_reg <= {quot_reg[Q_BITS-2:0], unit_q};
        end
        if (ctrl.do_coord) begin
            if (coord_y_reg) begin
                cy_reg   <= quot_reg[SIDE_BITS-1:0];
                y_ok_reg <= coord_ok;
            end else begin
                cx_reg   <= quot_reg[SIDE_BITS-1:0];
                x_ok_reg <= coord_ok;
            end
        end
        if (ctrl.do_index) begin
            addr_reg   <= cell_idx[CELL_AW-1:0];
            in_map_reg <= x_ok_reg && y_ok_reg && (32'(cell_idx) < 32'(MAP_CELLS));
        end
        if (ctrl.do_emit) begin
            m_data_reg <= M_TDATA_W'(hit_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Map writes go straight into the RAM and never hold the input off.
    a_map_write_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (in_kind == KIND_MAP)) |=> s_tready)
        else $error("map write did not leave the block ready");

    // The sticky hit is cleared once its result word has been loaded.
    a_hit_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.do_emit |=> (!hit_reg && m_tvalid))
        else $error("hit flag survived the result word");

    // The divider never runs past its last quotient bit.
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.do_step |-> (32'(step_reg) < Q_BITS))
        else $error("division step counter overran");

    // A result is only produced once the map is loaded.
    a_emit_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.do_emit |-> loaded_reg)
        else $error("result produced before the map was loaded");

endmodule

// ----- sv/gpoc_ram.sv -----
// Generic single-port RAM with registered read data.
module gpoc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/gpoc_divstep.sv -----
// One restoring division step: shift in a dividend bit, trial subtract, keep or restore.
module gpoc_divstep (
    input  logic [gpoc_pkg::COORD_W-1:0] rem,
    input  logic                         bit_in,
    input  logic [gpoc_pkg::DIV_W-1:0]   divisor,
    output logic [gpoc_pkg::COORD_W-1:0] rem_next,
    output logic                         q_bit
);
    import gpoc_pkg::*;

    logic [DIFF_W-1:0] total;
    logic [DIFF_W:0]   trial;

    always_comb begin
        total    = {rem, bit_in};
        trial    = {1'b0, total} - {{(DIFF_W + 1 - DIV_W){1'b0}}, divisor};
        q_bit    = ~trial[DIFF_W];
        rem_next = q_bit ? trial[COORD_W-1:0] : total[COORD_W-1:0];
    end

endmodule

// ----- sv/gpoc_seq.sv -----
// Sequencer that steps one path point through difference, division, index, map read, check and emit.
module gpoc_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gpoc_pkg::seq_status_t status,
    output gpoc_pkg::seq_ctrl_t   ctrl
);
    import gpoc_pkg::*;

    seq_state_t state_reg;
    seq_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (status.point_go) begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:  state_next = ST_ABS;
            ST_ABS:   state_next = ST_DIV;
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_COORD;
                end
            end
            ST_COORD: state_next = status.coord_y ? ST_INDEX : ST_DIFF;
            ST_INDEX: state_next = ST_READ;
            ST_READ:  state_next = ST_CHECK;
            ST_CHECK: state_next = status.last ? ST_EMIT : ST_IDLE;
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE:  ctrl.ready    = 1'b1;
            ST_DIFF:  ctrl.do_diff  = 1'b1;
            ST_ABS:   ctrl.do_abs   = 1'b1;
            ST_DIV:   ctrl.do_step  = 1'b1;
            ST_COORD: ctrl.do_coord = 1'b1;
            ST_INDEX: ctrl.do_index = 1'b1;
            ST_READ:  ctrl.do_read  = 1'b1;
            ST_CHECK: ctrl.do_check = 1'b1;
            ST_EMIT:  ctrl.do_emit  = status.out_free;
            default:  ctrl = '0;
        endcase
    end

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the grid path occupancy check.
`timescale 1ns / 1ps

module tb;
    import gpoc_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 40;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // cell_index[15:0], cell_value[23:16], point_x[55:24], point_y[87:56]
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    // kind[0]
    logic [0:0]            s_tuser = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // path_occupied[0], zero padding above
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Shadow of the block's registers and state
    logic signed [31:0]    reg_ox;
    logic signed [31:0]    reg_oy;
    logic [DIV_W-1:0]      reg_cs;
    logic [SIZE_W-1:0]     reg_w;
    logic [SIZE_W-1:0]     reg_h;
    logic signed [7:0]     reg_lim;
    logic signed [7:0]     grid_vals [MAP_CELLS];
    bit                    cell_written [MAP_CELLS];
    bit                    map_armed;
    bit                    hit_sticky;
    bit                    flags_due [$];

    int send_idle = 0;
    int recv_stall = 0;
    int hold_left = 0;
    int mismatches = 0;
    int cycle_count = 0;

    grid_path_occupancy_check DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    // A long hold-off takes precedence over the random stalls.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic report_bad(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (flags_due.size() == 0) begin
                report_bad($sformatf("unexpected word, path_occupied %0d", m_tdata[0]));
            end else begin
                if (m_tdata[0] !== flags_due[0])
                    report_bad($sformatf("path_occupied expected %0d got %0d",
                                         flags_due[0], m_tdata[0]));
                void'(flags_due.pop_front());
            end
        end
    end

    function automatic longint side_clip(input logic [SIZE_W-1:0] s);
        return (s > MAX_SIDE) ? longint'(MAX_SIDE) : longint'(s);
    endfunction

    // Cell that a point falls in under the current registers; 0 when off the map.
    function automatic bit cell_at(input logic signed [31:0] px,
                                   input logic signed [31:0] py, output int idx);
        longint dv, w, h, cx, cy;
        dv = (reg_cs == 0) ? 64'sd1 : longint'(reg_cs);
        w = side_clip(reg_w);
        h = side_clip(reg_h);
        cx = (longint'(px) - longint'(reg_ox)) / dv;
        cy = (longint'(py) - longint'(reg_oy)) / dv;
        idx = 0;
        if (cx < 0 || cx >= w || cy < 0 || cy >= h)
            return 1'b0;
        idx = int'(cy * w + cx);
        return idx < MAP_CELLS;
    endfunction

    task automatic absorb_word(input bit kind, input logic [15:0] ci, input logic [7:0] cv,
                               input logic signed [31:0] px, input logic signed [31:0] py,
                               input bit is_last);
        int idx;
        if (kind == KIND_MAP) begin
            grid_vals[ci] = cv;
            cell_written[ci] = 1'b1;
            if (is_last)
                map_armed = 1'b1;
        end else if (!map_armed) begin
            if (is_last)
                hit_sticky = 1'b0;
        end else begin
            if (cell_at(px, py, idx) && grid_vals[idx] > reg_lim)
                hit_sticky = 1'b1;
            if (is_last) begin
                flags_due.push_back(hit_sticky);
                hit_sticky = 1'b0;
            end
        end
    endtask

    // Offers one word and returns once it is taken; tvalid stays high until the
    // next call or a pause lowers it at the following falling edge.
    task automatic send_item(input bit kind, input logic [15:0] ci, input logic [7:0] cv,
                             input logic signed [31:0] px, input logic signed [31:0] py,
                             input bit is_last);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {py, px, cv, ci};
        s_tuser  <= kind;
        s_tlast  <= is_last;
        do
            @(posedge aclk);
        while (!s_tready);
        absorb_word(kind, ci, cv, px, py, is_last);
    endtask

    task automatic send_cell(input logic [15:0] ci, input logic [7:0] cv, input bit is_last);
        send_item(KIND_MAP, ci, cv, $urandom, $urandom, is_last);
    endtask

    task automatic send_point(input logic signed [31:0] px, input logic signed [31:0] py,
                              input bit is_last);
        send_item(KIND_POINT, 16'($urandom), 8'($urandom), px, py, is_last);
    endtask

    // Picks a point that either misses the map or lands on a cell already written.
    function automatic void pick_point(output logic signed [31:0] px,
                                       output logic signed [31:0] py);
        longint dv, w, h, tx, ty;
        int tries, idx;
        dv = (reg_cs == 0) ? 64'sd1 : longint'(reg_cs);
        w = side_clip(reg_w);
        h = side_clip(reg_h);
        for (tries = 0; tries < 40; tries++) begin
            case ($urandom_range(3))
                0: begin
                    tx = longint'($signed($urandom));
                    ty = longint'($signed($urandom));
                end
                3: begin
                    tx = longint'(reg_ox) - $urandom_range(0, 32'(dv - 1));
                    ty = longint'(reg_oy) - $urandom_range(0, 32'(dv - 1));
                end
                default: begin
                    tx = longint'(reg_ox) + (longint'($urandom_range(0, int'(w) + 1)) - 1) * dv
                         + $urandom_range(0, 32'(dv - 1));
                    ty = longint'(reg_oy) + (longint'($urandom_range(0, int'(h) + 1)) - 1) * dv
                         + $urandom_range(0, 32'(dv - 1));
                end
            endcase
            if (tx >= -64'sd2147483648 && tx <= 64'sd2147483647 &&
                ty >= -64'sd2147483648 && ty <= 64'sd2147483647) begin
                px = 32'(tx);
                py = 32'(ty);
                if (!cell_at(px, py, idx) || cell_written[idx])
                    return;
            end
        end
        // The origin falls in cell 0, which is written early on.
        px = reg_ox;
        py = reg_oy;
    endfunction

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (flags_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
    endtask

    task automatic program_regs(input logic [31:0] ox, input logic [31:0] oy,
                                input logic [DIV_W-1:0] cs, input logic [SIZE_W-1:0] w,
                                input logic [SIZE_W-1:0] h, input logic [7:0] lim);
        settle();
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_CELL_SIZE, {1'b0, cs});
        write_reg(REG_MAP_W, {23'd0, w});
        write_reg(REG_MAP_H, {23'd0, h});
        write_reg(REG_LIMIT, {24'd0, lim});
        @(negedge aclk);
        cfg_we <= 1'b0;
        reg_ox  = ox;
        reg_oy  = oy;
        reg_cs  = cs;
        reg_w   = w;
        reg_h   = h;
        reg_lim = lim;
    endtask

    // Paths of random length with map updates mixed in, most of them near the
    // threshold or inside the current map area.
    task automatic run_mix(input int n);
        int i;
        longint w, h;
        logic [15:0] ci;
        logic [7:0] cv;
        logic signed [31:0] px, py;
        w = side_clip(reg_w);
        h = side_clip(reg_h);
        for (i = 0; i < n; i++) begin
            if ($urandom_range(99) < 25) begin
                if (w > 0 && h > 0 && $urandom_range(9) < 7)
                    ci = 16'($urandom_range(0, int'(h) - 1) * w + $urandom_range(0, int'(w) - 1));
                else
                    ci = 16'($urandom);
                cv = $urandom_range(1) ? 8'($urandom_range(0, 101) - 1) : 8'($urandom);
                send_cell(ci, cv, $urandom_range(19) == 0);
            end else begin
                pick_point(px, py);
                send_point(px, py, $urandom_range(2) == 0);
            end
        end
    endtask

    task automatic test_directed();
        // Points before any map is loaded are dropped, even with a last point.
        send_point(32'sh8000_0000, 32'sd0, 1'b0);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
        send_cell(16'd0, 8'd100, 1'b0);
        send_point(32'sd0, 32'sd0, 1'b1);
        send_cell(16'd1, 8'hFF, 1'b0);
        send_cell(16'd256, 8'd51, 1'b0);
        send_cell(16'd257, 8'd50, 1'b0);
        send_cell(16'hFFFF, 8'd127, 1'b0);
        send_cell(16'h5555, 8'h80, 1'b1);
        send_point(32'sd0, 32'sd0, 1'b1);
        send_point(32'sd65536, 32'sd0, 1'b1);
        send_point(32'sd0, 32'sd65536, 1'b1);
        // A value equal to the limit is not occupied.
        send_point(32'sd131071, 32'sd65537, 1'b1);
        // Slightly below the origin still truncates into the first cell.
        send_point(-32'sd1, -32'sd65535, 1'b1);
        send_point(32'sd16711680, 32'sd16777215, 1'b1);
        send_point(32'sd5570560, 32'sd5570560, 1'b1);
        send_point(32'sd16777216, 32'sd0, 1'b1);
        send_point(32'sd0, -32'sd65536, 1'b1);
        // The hit flag holds through the rest of the path.
        send_point(32'sd0, 32'sd0, 1'b0);
        send_point(32'sd65536, 32'sd0, 1'b0);
        send_point(32'sh8000_0000, 32'sh8000_0000, 1'b1);
        // A cell rewritten halfway through a path counts for the later points.
        send_point(32'sd65536, 32'sd0, 1'b0);
        send_cell(16'd1, 8'd90, 1'b0);
        send_point(32'sd65536, 32'sd0, 1'b1);
    endtask

    task automatic test_config_extremes();
        program_regs(32'h8000_0000, 32'h7FFF_FFFF, 31'd1, 9'd256, 9'd256, 8'h80);
        run_mix(14);
        program_regs(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 9'd1, 9'd1, 8'd127);
        run_mix(14);
        // Zero cell size acts as one; oversized sides clip to the maximum.
        program_regs(32'd0, 32'd0, 31'd0, 9'd511, 9'd511, 8'hFF);
        run_mix(14);
        program_regs(32'h0001_0000, 32'hFFFE_0000, 31'h8000, 9'd0, 9'd16, 8'd0);
        run_mix(14);
        program_regs(32'hFFFE_1DC0, 32'h0009_FBF1, 31'd3, 9'd16, 9'd0, 8'd100);
        run_mix(14);
        program_regs(32'd0, 32'd0, 31'd65536, 9'd3, 9'd2, 8'd50);
        run_mix(14);
        program_regs(32'h1234_5678, 32'hEDCB_A987, 31'd1000, 9'd256, 9'd1, 8'hFF);
        run_mix(14);
    endtask

    task automatic randomise_regs();
        logic [31:0] ox, oy;
        logic [DIV_W-1:0] cs;
        ox = $urandom_range(1) ? $urandom : 32'($urandom_range(0, 2000000) - 1000000);
        oy = $urandom_range(1) ? $urandom : 32'($urandom_range(0, 2000000) - 1000000);
        case ($urandom_range(2))
            0:       cs = 31'($urandom_range(1, 255));
            1:       cs = 31'($urandom_range(30000, 140000));
            default: cs = 31'($urandom_range(1, 32'h7FFF_FFFF));
        endcase
        program_regs(ox, oy, cs,
                     ($urandom_range(9) == 0) ? 9'd256 : 9'($urandom_range(1, 24)),
                     ($urandom_range(9) == 0) ? 9'd256 : 9'($urandom_range(1, 24)),
                     8'($urandom_range(0, 101) - 1));
    endtask

    task automatic test_idle_phases();
        randomise_regs();
        run_mix(80);
        send_idle = 88;
        randomise_regs();
        run_mix(80);
        send_idle = 0;
        recv_stall = 88;
        randomise_regs();
        run_mix(80);
        send_idle = 34;
        recv_stall = 34;
        randomise_regs();
        run_mix(80);
        send_idle = 0;
        recv_stall = 0;
    endtask

    // Every word ends a path, so result words pile up behind a stalled receiver
    // and the block has to stop taking input.
    task automatic test_output_hold();
        int i;
        logic signed [31:0] px, py;
        settle();
        hold_left = 600;
        for (i = 0; i < 12; i++) begin
            pick_point(px, py);
            send_point(px, py, 1'b1);
        end
    endtask

    initial begin
        reg_ox = '0;
        reg_oy = '0;
        reg_cs = CELL_SIZE_RST;
        reg_w = MAP_SIDE_RST;
        reg_h = MAP_SIDE_RST;
        reg_lim = LIMIT_RST;
        map_armed = 1'b0;
        hit_sticky = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_config_extremes();
        test_idle_phases();
        test_output_hold();
        settle();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
